// ===== rtl/b2b_pkg.sv =====
package b2b_pkg;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0008;

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // One queued beat from front to back: masked word plus its class.
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } beat_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

endpackage

// ===== rtl/b2b_front.sv =====
module b2b_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [63:0]    msg_word,
  input  logic [3:0]     valid_bytes,
  input  logic           last,
  input  logic           valid,
  output logic           stall,
  output b2b_pkg::beat_t q_beat,
  output logic           q_valid,
  input  logic           q_pop
);

  b2b_pkg::beat_t             mem [b2b_pkg::QDEPTH];
  logic [b2b_pkg::QAW-1:0]    wptr;
  logic [b2b_pkg::QAW-1:0]    rptr;
  logic [b2b_pkg::QAW:0]      count;
  logic                       push;
  logic [3:0]                 nb;
  logic [63:0]                mask;
  b2b_pkg::beat_t             in_beat;

  // Classify: non-last counts 8, clamp over-long counts, mask tail bytes.
  always_comb begin
    if (!last) begin
      nb = 4'd8;
    end else if (valid_bytes > 4'd8) begin
      nb = 4'd8;
    end else begin
      nb = valid_bytes;
    end
    for (int i = 0; i < 8; i++) begin
      mask[i*8 +: 8] = (4'(i) < nb) ? 8'hff : 8'h00;
    end
    in_beat.word   = msg_word & mask;
    in_beat.nbytes = nb;
    in_beat.last   = last;
  end

  assign stall   = (count == (b2b_pkg::QAW+1)'(b2b_pkg::QDEPTH));
  assign push    = valid && !stall;
  assign q_valid = (count != '0);
  assign q_beat  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      count <= count + (b2b_pkg::QAW+1)'(push) - (b2b_pkg::QAW+1)'(q_pop);
    end
  end

endmodule

// ===== rtl/b2b_back.sv =====
module b2b_back (
  input  logic           clk,
  input  logic           rst,
  input  b2b_pkg::beat_t q_beat,
  input  logic           q_valid,
  output logic           q_pop,
  output logic [63:0]    hash_value,
  output logic           out_valid,
  input  logic           out_stall
);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_MIX, S_FIN, S_OUT} state_t;

  state_t       state;
  logic [63:0]  h [8];
  logic [63:0]  m [16];
  logic [63:0]  v [16];
  logic [63:0]  cnt_lo;
  logic [63:0]  cnt_hi;
  logic [4:0]   fill;
  logic         final_blk;
  logic         pend_last;
  logic [3:0]   rnd;
  logic [2:0]   gi;
  logic         half;

  // Shared G unit: one half of a G function each cycle.
  logic [3:0]   ia, ib, ic, id, sx;
  logic [63:0]  a0, b0, c0, d0, x;
  logic [63:0]  a1, b1, c1, d1;
  logic [3:0]   rsel;

  always_comb begin
    unique case (gi)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
    rsel = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
    sx   = b2b_pkg::SIGMA[rsel][{gi, half}];
    x    = m[sx];
    a0 = v[ia]; b0 = v[ib]; c0 = v[ic]; d0 = v[id];
    a1 = a0 + b0 + x;
    if (!half) begin
      d1 = d0 ^ a1; d1 = {d1[31:0], d1[63:32]};
      c1 = c0 + d1;
      b1 = b0 ^ c1; b1 = {b1[23:0], b1[63:24]};
    end else begin
      d1 = d0 ^ a1; d1 = {d1[15:0], d1[63:16]};
      c1 = c0 + d1;
      b1 = b0 ^ c1; b1 = {b1[62:0], b1[63]};
    end
  end

  logic take;
  logic flush;
  assign take  = (state == S_IDLE) && q_valid;
  assign flush = take && (q_beat.nbytes != 4'd0) && (fill == 5'd16);
  // Hold the beat in the queue while a full block is flushed first.
  assign q_pop = take && !flush;

  logic [64:0] sum;
  assign sum = {1'b0, cnt_lo} + {61'd0, q_beat.nbytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 1; i < 8; i++) h[i] <= b2b_pkg::IV[i];
      h[0]      <= b2b_pkg::IV[0] ^ b2b_pkg::PARAM_WORD;
      for (int i = 0; i < 16; i++) m[i] <= '0;
      cnt_lo    <= '0;
      cnt_hi    <= '0;
      fill      <= '0;
      pend_last <= 1'b0;
      final_blk <= 1'b0;
      rnd       <= '0;
      gi        <= '0;
      half      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (flush) begin
            final_blk <= 1'b0;
            pend_last <= 1'b0;
            state     <= S_INIT;
          end else if (take) begin
            if (q_beat.nbytes != 4'd0) begin
              m[fill[3:0]] <= q_beat.word;
              fill         <= fill + 5'd1;
              cnt_lo       <= sum[63:0];
              if (sum[64]) cnt_hi <= cnt_hi + 64'd1;
            end
            if (q_beat.last) begin
              final_blk <= 1'b1;
              pend_last <= 1'b1;
              state     <= S_INIT;
            end
          end
        end
        S_INIT: begin
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          for (int i = 0; i < 4; i++) v[i + 8] <= b2b_pkg::IV[i];
          v[12] <= b2b_pkg::IV[4] ^ cnt_lo;
          v[13] <= b2b_pkg::IV[5] ^ cnt_hi;
          v[14] <= final_blk ? ~b2b_pkg::IV[6] : b2b_pkg::IV[6];
          v[15] <= b2b_pkg::IV[7];
          rnd   <= '0;
          gi    <= '0;
          half  <= 1'b0;
          state <= S_MIX;
        end
        S_MIX: begin
          v[ia] <= a1; v[ib] <= b1; v[ic] <= c1; v[id] <= d1;
          half <= !half;
          if (half) begin
            gi <= gi + 3'd1;
            if (gi == 3'd7) begin
              if (rnd == 4'd11) state <= S_FIN;
              else rnd <= rnd + 4'd1;
            end
          end
        end
        S_FIN: begin
          if (pend_last) begin
            for (int k = 0; k < 8; k++) begin
              hash_value[63 - 8*k -: 8] <= (h[0][8*k +: 8] ^ v[0][8*k +: 8] ^
                                            v[8][8*k +: 8]);
            end
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            for (int i = 0; i < 8; i++) h[i] <= h[i] ^ v[i] ^ v[i + 8];
            for (int i = 0; i < 16; i++) m[i] <= '0;
            fill  <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            for (int i = 1; i < 8; i++) h[i] <= b2b_pkg::IV[i];
            h[0]      <= b2b_pkg::IV[0] ^ b2b_pkg::PARAM_WORD;
            for (int i = 0; i < 16; i++) m[i] <= '0;
            cnt_lo    <= '0;
            cnt_hi    <= '0;
            fill      <= '0;
            pend_last <= 1'b0;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/blake2b_64_hash.sv =====
// Unkeyed BLAKE2b, 8-byte digest, over a stream of 64-bit message beats.
// Input channel: msg_word (first byte in bits 7..0), valid_bytes, last,
// with in_valid / in_stall. A beat is taken when in_valid is high and
// in_stall low. Non-last beats always count eight bytes; the last beat
// counts valid_bytes (clamped to eight) and its unused bytes are zeroed.
// An empty message is a single last beat with no valid bytes.
// Output channel: hash_value with out_valid / out_stall, one beat per
// message: digest bytes 0..7 read big-endian, as a signed value.
// The front stage masks and classifies beats into a four-entry queue;
// the back stage packs words into a block and runs the compression on a
// single shared half-G unit: 12 rounds x 16 half-steps, after a set-up
// state and before a finalisation state. A plain word goes straight into
// the block; a word that follows a full block waits while that block is
// compressed; the last block is compressed before the result appears.
// Reset clears the chain value to the parameterised IV and empties the
// queue. While out_stall is high the result holds and the back stage
// waits; the front queue keeps taking beats until it fills.
module blake2b_64_hash (
  input  logic               clk,
  input  logic               rst,
  input  logic [63:0]        msg_word,
  input  logic [3:0]         valid_bytes,
  input  logic               last,
  input  logic               in_valid,
  output logic               in_stall,
  output logic signed [63:0] hash_value,
  output logic               out_valid,
  input  logic               out_stall
);

  b2b_pkg::beat_t q_beat;
  logic           q_valid;
  logic           q_pop;
  logic [63:0]    hv;

  b2b_front u_front (
    .clk, .rst, .msg_word, .valid_bytes, .last,
    .valid(in_valid), .stall(in_stall),
    .q_beat, .q_valid, .q_pop
  );

  b2b_back u_back (
    .clk, .rst, .q_beat, .q_valid, .q_pop,
    .hash_value(hv), .out_valid, .out_stall
  );

  assign hash_value = signed'(hv);

endmodule
